// ----- src/mbwfb_pkg.sv -----
// mbwfb_pkg: shared constants and the crc-16 byte update for the modbus write frame builder
// no dependencies
package mbwfb_pkg;

	localparam int unsigned FrameLen = 11;
	localparam int unsigned CrcLen = 9;
	localparam int unsigned PosW = 4;

	localparam logic [7:0] FUNC_WRITE_MULTI = 8'd16;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// byte positions inside the frame
	localparam logic [PosW-1:0] POS_DEV = 4'd0;
	localparam logic [PosW-1:0] POS_FUNC = 4'd1;
	localparam logic [PosW-1:0] POS_ADDR_HI = 4'd2;
	localparam logic [PosW-1:0] POS_ADDR_LO = 4'd3;
	localparam logic [PosW-1:0] POS_CNT_HI = 4'd4;
	localparam logic [PosW-1:0] POS_CNT_LO = 4'd5;
	localparam logic [PosW-1:0] POS_BYTES = 4'd6;
	localparam logic [PosW-1:0] POS_VAL_HI = 4'd7;
	localparam logic [PosW-1:0] POS_VAL_LO = 4'd8;
	localparam logic [PosW-1:0] POS_CRC_LO = 4'd9;
	localparam logic [PosW-1:0] POS_CRC_HI = 4'd10;

	localparam logic [7:0] REG_COUNT_HI = 8'd0;
	localparam logic [7:0] REG_COUNT_LO = 8'd1;
	localparam logic [7:0] BYTE_COUNT = 8'd2;

	// one byte of crc-16/modbus, lsb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- src/modbus_write_frame_builder_unit.sv -----
// modbus_write_frame_builder_unit: turns a register write request into an 11-byte
// modbus rtu write-multiple-registers frame, one byte per output transfer
// depends on mbwfb_pkg
//
// Each accepted request produces eleven output bytes in transmit order: device address,
// function 16, register address high/low, register count 0,1, byte count 2, value high/low,
// then the crc-16 (init 0xFFFF, poly 0xA001 reflected) low and high bytes. last_byte marks
// the crc high byte, and awaiting_response is set on it unless the request asked to ignore
// the reply. The block emits one byte per cycle while the output side takes them; the crc
// advances by one byte per cycle alongside the serializer. A one-entry request buffer takes
// the next request while the current frame is still being sent, so frames follow each other
// with no gap. device_address is written through cfg_wr_en and cfg_wr_data (reset value 1)
// and must only change while no frame is in flight.
module modbus_write_frame_builder_unit
	import mbwfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [15:0] target_reg,
	input  logic [15:0] reg_data,
	input  logic        skip_reply,
	output logic        byte_valid,
	input  logic        byte_ready,
	output logic [7:0]  frame_byte,
	output logic        last_byte,
	output logic        awaiting_response
);

	logic [7:0] device_address_q;

	// request buffer
	logic        buf_valid_s1;
	logic [15:0] buf_addr_s1;
	logic [15:0] buf_val_s1;
	logic        buf_ign_s1;

	// serializer state
	logic            busy_q;
	logic [PosW-1:0] pos_q;
	logic [15:0]     crc_q;
	logic [15:0]     held_addr_q;
	logic [15:0]     held_val_q;
	logic            held_ign_q;

	// output register
	logic       byte_valid_q;
	logic [7:0] frame_byte_q;
	logic       last_byte_q;
	logic       await_q;

	logic            gen_active;
	logic            advance;
	logic [PosW-1:0] cur_pos;
	logic [15:0]     cur_crc;
	logic [15:0]     cur_addr;
	logic [15:0]     cur_val;
	logic            cur_ign;
	logic [7:0]      cur_byte;
	logic            cur_last;

	assign req_ready = ~buf_valid_s1;
	assign byte_valid = byte_valid_q;
	assign frame_byte = frame_byte_q;
	assign last_byte = last_byte_q;
	assign awaiting_response = await_q;

	assign gen_active = busy_q | buf_valid_s1;
	assign advance = gen_active & (~byte_valid_q | byte_ready);

	// a new frame starts straight from the buffer
	assign cur_pos = busy_q ? pos_q : POS_DEV;
	assign cur_crc = busy_q ? crc_q : CRC_INIT;
	assign cur_addr = busy_q ? held_addr_q : buf_addr_s1;
	assign cur_val = busy_q ? held_val_q : buf_val_s1;
	assign cur_ign = busy_q ? held_ign_q : buf_ign_s1;
	assign cur_last = (cur_pos == POS_CRC_HI);

	always_comb begin
		case (cur_pos)
			POS_DEV: cur_byte = device_address_q;
			POS_FUNC: cur_byte = FUNC_WRITE_MULTI;
			POS_ADDR_HI: cur_byte = cur_addr[15:8];
			POS_ADDR_LO: cur_byte = cur_addr[7:0];
			POS_CNT_HI: cur_byte = REG_COUNT_HI;
			POS_CNT_LO: cur_byte = REG_COUNT_LO;
			POS_BYTES: cur_byte = BYTE_COUNT;
			POS_VAL_HI: cur_byte = cur_val[15:8];
			POS_VAL_LO: cur_byte = cur_val[7:0];
			POS_CRC_LO: cur_byte = cur_crc[7:0];
			POS_CRC_HI: cur_byte = cur_crc[15:8];
			default: cur_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= 8'd1;
		end else if (cfg_wr_en) begin
			device_address_q <= cfg_wr_data;
		end
	end

	// request buffer: filled on an input transfer, drained when a frame starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			buf_valid_s1 <= 1'b1;
		end else if (advance && !busy_q) begin
			buf_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			buf_addr_s1 <= target_reg;
			buf_val_s1 <= reg_data;
			buf_ign_s1 <= skip_reply;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q <= POS_DEV;
		end else if (advance) begin
			if (cur_last) begin
				busy_q <= 1'b0;
				pos_q <= POS_DEV;
			end else begin
				busy_q <= 1'b1;
				pos_q <= cur_pos + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			held_addr_q <= cur_addr;
			held_val_q <= cur_val;
			held_ign_q <= cur_ign;
			// crc covers the header and data bytes only
			if (cur_pos < PosW'(CrcLen)) begin
				crc_q <= crc_byte(cur_crc, cur_byte);
			end else begin
				crc_q <= cur_crc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_q <= 1'b0;
		end else if (advance) begin
			byte_valid_q <= 1'b1;
		end else if (byte_ready) begin
			byte_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_byte_q <= cur_byte;
			last_byte_q <= cur_last;
			await_q <= cur_last & ~cur_ign;
		end
	end

endmodule

// ----- sim/tb.sv -----
// tb: self-checking testbench for modbus_write_frame_builder_unit
// builds each expected 11-byte frame and its crc locally and checks every output byte
// depends on mbwfb_pkg and modbus_write_frame_builder_unit
`timescale 1ns / 100ps

module tb;
	import mbwfb_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int IDLE_PCT = 34;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [15:0] reg_addr;
		logic [15:0] value;
		logic        no_reply;
	} write_req_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       reply;
	} frame_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = 8'd0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [15:0] target_reg = 16'd0;
	logic [15:0] reg_data = 16'd0;
	logic        skip_reply = 1'b0;
	logic        byte_valid;
	logic        byte_ready = 1'b0;
	logic [7:0]  frame_byte;
	logic        last_byte;
	logic        awaiting_response;

	write_req_t  pending_reqs[$];
	frame_byte_t expected_bytes[$];
	logic [7:0]  dev_addr = 8'd1;
	logic        calm = 1'b0;
	logic        req_fire = 1'b0;
	int          queued_count = 0;
	int          accepted_count = 0;
	int          stall_cycles = 0;
	int          mismatches = 0;
	int          byte_count = 0;
	frame_byte_t got_byte;
	frame_byte_t want_byte;
	write_req_t  next_req;

	modbus_write_frame_builder_unit i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.req_valid         (req_valid),
		.req_ready         (req_ready),
		.target_reg        (target_reg),
		.reg_data          (reg_data),
		.skip_reply        (skip_reply),
		.byte_valid        (byte_valid),
		.byte_ready        (byte_ready),
		.frame_byte        (frame_byte),
		.last_byte         (last_byte),
		.awaiting_response (awaiting_response)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected frame for one write request, crc-16/modbus over the first nine bytes
	function automatic void predict_frame(input write_req_t r);
		logic [7:0]  frame [FrameLen];
		logic [15:0] crc;
		frame_byte_t fb;
		frame[0] = dev_addr;
		frame[1] = FUNC_WRITE_MULTI;
		frame[2] = r.reg_addr[15:8];
		frame[3] = r.reg_addr[7:0];
		frame[4] = REG_COUNT_HI;
		frame[5] = REG_COUNT_LO;
		frame[6] = BYTE_COUNT;
		frame[7] = r.value[15:8];
		frame[8] = r.value[7:0];
		crc = CRC_INIT;
		for (int i = 0; i < CrcLen; i++) begin
			crc = crc ^ {8'h00, frame[i]};
			for (int k = 0; k < 8; k++) begin
				if (crc[0]) begin
					crc = (crc >> 1) ^ CRC_POLY;
				end else begin
					crc = crc >> 1;
				end
			end
		end
		frame[9] = crc[7:0];
		frame[10] = crc[15:8];
		for (int i = 0; i < FrameLen; i++) begin
			fb.data = frame[i];
			fb.last = (i == FrameLen - 1);
			fb.reply = (i == FrameLen - 1) && !r.no_reply;
			expected_bytes.push_back(fb);
		end
	endfunction

	function automatic logic [15:0] rand_word();
		// bias toward the all-zero and all-one corners now and then
		case ($urandom_range(7))
			0: rand_word = 16'h0000;
			1: rand_word = 16'hFFFF;
			default: rand_word = 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// request transfers are predicted before output bytes are checked
	always @(posedge clk) begin
		req_fire <= arst_n && req_valid && req_ready;
		if (!arst_n) begin
			stall_cycles <= 0;
		end else begin
			if ((req_valid && req_ready) || (byte_valid && byte_ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (req_valid && req_ready) begin
				predict_frame('{target_reg, reg_data, skip_reply});
				accepted_count++;
			end
			if (byte_valid && byte_ready) begin
				got_byte = '{frame_byte, last_byte, awaiting_response};
				if (expected_bytes.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected byte %02h last %0b await %0b with no frame pending",
							got_byte.data, got_byte.last, got_byte.reply);
				end else begin
					want_byte = expected_bytes.pop_front();
					if (got_byte !== want_byte) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("byte %0d: expected %02h last %0b await %0b, got %02h last %0b await %0b",
								byte_count, want_byte.data, want_byte.last, want_byte.reply,
								got_byte.data, got_byte.last, got_byte.reply);
					end
				end
				byte_count++;
			end
		end
	end

	// driver: requests and output ready change on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			byte_ready <= 1'b0;
		end else begin
			byte_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			if (!req_valid || req_fire) begin
				if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					next_req = pending_reqs.pop_front();
					req_valid <= 1'b1;
					target_reg <= next_req.reg_addr;
					reg_data <= next_req.value;
					skip_reply <= next_req.no_reply;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	function automatic void add_req(input logic [15:0] a, input logic [15:0] v, input logic n);
		pending_reqs.push_back('{a, v, n});
		queued_count++;
	endfunction

	task automatic wait_drained();
		do @(negedge clk);
		while (accepted_count != queued_count || expected_bytes.size() != 0);
		@(posedge clk);
	endtask

	task automatic set_device_address(input logic [7:0] a);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= a;
		dev_addr = a;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_regression();
		logic [7:0] phase_addr [8];
		phase_addr = '{8'd0, 8'd247, 8'd255, 8'd248, 8'd0, 8'd0, 8'd0, 8'd0};
		for (int p = 4; p < 8; p++)
			phase_addr[p] = 8'($urandom_range(255));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field corners at the reset device address
		add_req(16'h0000, 16'h0000, 1'b0);
		add_req(16'hFFFF, 16'hFFFF, 1'b1);
		add_req(16'hFFFF, 16'h0000, 1'b0);
		add_req(16'h0000, 16'hFFFF, 1'b1);
		add_req(16'h8000, 16'h0001, 1'b0);
		add_req(16'h0001, 16'h8000, 1'b1);
		add_req(16'h00FF, 16'hFF00, 1'b0);
		add_req(16'hFF00, 16'h00FF, 1'b1);
		add_req(16'hAAAA, 16'h5555, 1'b0);
		add_req(16'h5555, 16'hAAAA, 1'b1);
		wait_drained();

		// address extremes, out of range values, then random addresses
		for (int p = 0; p < 8; p++) begin
			set_device_address(phase_addr[p]);
			calm = (p == 2);
			for (int i = 0; i < 25; i++)
				add_req(rand_word(), rand_word(), 1'($urandom_range(1)));
			wait_drained();
			calm = 1'b0;
		end

		// back to the reset value
		set_device_address(8'd1);
		add_req(16'h1234, 16'hBEEF, 1'b0);
		add_req(16'hFFFF, 16'hFFFF, 1'b0);
		wait_drained();
		repeat (30) @(posedge clk);
	endtask

	initial begin
		fork
			run_regression();
			wait (stall_cycles >= STALL_LIMIT);
		join_any
		disable fork;
		if (stall_cycles < STALL_LIMIT && mismatches == 0) begin
			$display("modbus_write_frame_builder_unit regression: pass");
		end else begin
			$display("modbus_write_frame_builder_unit regression: fail");
		end
		$finish;
	end

endmodule
